>>> design/sliding_median_outlier_flag_core_macros.svh
// assertion macros for the sliding median outlier flag core
`ifndef SLIDING_MEDIAN_OUTLIER_FLAG_CORE_MACROS_SVH
`define SLIDING_MEDIAN_OUTLIER_FLAG_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SMOF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMOF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMOF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SMOF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/smof_pkg.sv
// shared constants for the sliding median outlier flag core
package smof_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;
    localparam int COUNT_W         = 32;
    localparam int SIZE_RESET      = 5;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> design/sliding_median_outlier_flag_core.sv
// sliding window median outlier flag, top level
//
// input channel: sample with in_valid / in_stall, a transfer when valid and not stall
// output channel: window_full, alert, alert_count with out_valid / out_stall
// config channel: window_size with cfg_valid / cfg_ready, always ready; write only
//   while idle, it sets the window length (0 reads as 1, above WINDOW_MAX clamps)
//   and empties the window, the alert count is kept
// the window lives in a row of sorted cells, each tagged with its age; a full window
// drops the cell of the oldest age, every item inserts the sample by parallel compare
// and shift, while the median is picked from the cells of the preceding window
// a sample lands in the input register, and its result moves into the output
// register once that register is empty or its result is taken
// throughput: one item per cycle while the output is not stalled, set by the single cell update pass
// a held result does not block the input register; stall reaches the input only
// when both the input register and the output register are occupied
// reset: window empty, window_size 5, alert count zero, no result pending
`include "sliding_median_outlier_flag_core_macros.svh"

module sliding_median_outlier_flag_core
    import smof_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   window_full,
    output logic                   alert,
    output logic [COUNT_W-1:0]     alert_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       window_size
);

    localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EXT_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int RST_SIZE = (SIZE_RESET > WINDOW_MAX) ? WINDOW_MAX : SIZE_RESET;

    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   window_full_reg;
    logic                   alert_reg;
    count_t                 count_reg, count_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [SIZE_W-1:0]      fill_reg, fill_next;

    logic [SAMPLE_BITS-1:0] cell_val_reg  [WINDOW_MAX];
    logic [IDX_W-1:0]       cell_age_reg  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_val_next [WINDOW_MAX];
    logic [IDX_W-1:0]       cell_age_next [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] b_val [WINDOW_MAX];
    logic [IDX_W-1:0]       b_age [WINDOW_MAX];

    logic [WINDOW_MAX-1:0]  le_vec;
    logic [WINDOW_MAX-1:0]  oldest_vec;
    logic [WINDOW_MAX-1:0]  ble_vec;
    logic [IDX_W-1:0]       rm_idx;
    logic [IDX_W-1:0]       hi_idx;
    logic [IDX_W-1:0]       lo_idx;
    logic [IDX_W-1:0]       oldest_age;
    logic [SIZE_W-1:0]      keep_cnt;
    logic [SAMPLE_BITS-1:0] med_lo;
    logic [SAMPLE_BITS-1:0] med_hi;
    logic [SAMPLE_BITS:0]   thresh;
    logic                   is_full;
    logic                   s1_alert;
    logic                   advance;
    logic                   in_take;
    logic                   cfg_take;
    logic [EXT_W-1:0]       size_ext;

    assign cfg_ready   = 1'b1;
    assign cfg_take    = cfg_valid && cfg_ready;
    assign advance     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = s1_valid_reg && !advance;
    assign in_take     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign window_full = window_full_reg;
    assign alert       = alert_reg;
    assign alert_count = count_reg;

    assign is_full    = (fill_reg >= size_reg);
    assign keep_cnt   = is_full ? (size_reg - SIZE_W'(1)) : fill_reg;
    assign oldest_age = IDX_W'(size_reg - SIZE_W'(1));
    assign hi_idx     = IDX_W'(size_reg >> 1);
    assign lo_idx     = size_reg[0] ? hi_idx : (hi_idx - IDX_W'(1));

    // median pick, removal search and compare against the new sample
    always_comb
    begin
        med_lo = '0;
        med_hi = '0;
        rm_idx = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            le_vec[i]     = (cell_val_reg[i] <= s1_sample_reg);
            oldest_vec[i] = is_full && (SIZE_W'(i) < size_reg)
                            && (cell_age_reg[i] == oldest_age);
            if (oldest_vec[i])
            begin
                rm_idx = rm_idx | IDX_W'(i);
            end
            if (IDX_W'(i) == lo_idx)
            begin
                med_lo = med_lo | cell_val_reg[i];
            end
            if (IDX_W'(i) == hi_idx)
            begin
                med_hi = med_hi | cell_val_reg[i];
            end
        end
        thresh   = {1'b0, med_lo} + {1'b0, med_hi};
        s1_alert = is_full && ({1'b0, s1_sample_reg} >= thresh);
    end

    // close the gap of the removed cell, then insert after equal values
    always_comb
    begin
        int up;
        int dn;
        logic sh;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            up = (i < WINDOW_MAX - 1) ? i + 1 : i;
            sh = is_full && (IDX_W'(i) >= rm_idx);
            b_val[i]   = sh ? cell_val_reg[up] : cell_val_reg[i];
            b_age[i]   = sh ? cell_age_reg[up] : cell_age_reg[i];
            ble_vec[i] = (SIZE_W'(i) < keep_cnt) && (sh ? le_vec[up] : le_vec[i]);
        end
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            dn = (i > 0) ? i - 1 : 0;
            if (ble_vec[i])
            begin
                cell_val_next[i] = b_val[i];
                cell_age_next[i] = b_age[i] + IDX_W'(1);
            end
            else if (i == 0 || ble_vec[dn])
            begin
                cell_val_next[i] = s1_sample_reg;
                cell_age_next[i] = '0;
            end
            else
            begin
                cell_val_next[i] = b_val[dn];
                cell_age_next[i] = b_age[dn] + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        size_ext = EXT_W'(window_size);
        if (size_ext == '0)
        begin
            size_next = SIZE_W'(1);
        end
        else if (size_ext > EXT_W'(WINDOW_MAX))
        begin
            size_next = SIZE_W'(WINDOW_MAX);
        end
        else
        begin
            size_next = SIZE_W'(size_ext);
        end

        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);

        if (cfg_take)
        begin
            fill_next = '0;
        end
        else if (advance && !is_full)
        begin
            fill_next = fill_reg + SIZE_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end

        if (advance && s1_alert && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            size_reg      <= SIZE_W'(RST_SIZE);
            fill_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            if (cfg_take)
            begin
                size_reg <= size_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
        end
        if (advance)
        begin
            window_full_reg <= is_full;
            alert_reg       <= s1_alert;
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                cell_val_reg[i] <= cell_val_next[i];
                cell_age_reg[i] <= cell_age_next[i];
            end
        end
    end

    `SMOF_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= size_reg, "fill above window size")
    `SMOF_ASSERT_IMPL(a_one_oldest, clk, rst_n, s1_valid_reg && is_full, $onehot(oldest_vec), "oldest cell not unique")
    `SMOF_ASSERT_IMPL(a_alert_full, clk, rst_n, out_valid_reg, !alert_reg || window_full_reg, "alert without full window")
    `SMOF_ASSERT_NEXT(a_count_hold, clk, rst_n, !(advance && s1_alert), $stable(count_reg), "count moved without alert")

endmodule

>>> bench/tb_sliding_median_outlier_flag_core.sv
`timescale 1ns / 100ps
// testbench for the sliding median outlier flag core: directed and random samples against a predictor
module tb_sliding_median_outlier_flag_core;
    import smof_pkg::*;

    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic   full;
        logic   alert;
        count_t count;
    } median_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                       in_valid;
    logic                       in_stall;
    logic [SAMPLE_BITS_DEF-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic                       window_full;
    logic                       alert;
    count_t                     alert_count;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           window_size;

    // predictor state
    logic [CFG_W-1:0]           cur_size = CFG_W'(SIZE_RESET);
    logic [SAMPLE_BITS_DEF-1:0] win_sorted [WINDOW_MAX_DEF];
    logic [SAMPLE_BITS_DEF-1:0] win_ring [WINDOW_MAX_DEF];
    int                         fill = 0;
    int                         oldest = 0;
    count_t                     alert_total = '0;

    median_result_t flag_exp_q [$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit long_hold_req = 1'b0;
    int samples_sent = 0;
    int results_checked = 0;
    int size_writes = 0;
    int fail_count = 0;

    sliding_median_outlier_flag_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .window_full (window_full),
        .alert       (alert),
        .alert_count (alert_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .window_size (window_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void sorted_insert(input int n, input logic [SAMPLE_BITS_DEF-1:0] v);
        int pos;
        int k;
        pos = 0;
        while (pos < n && win_sorted[pos] <= v)
            pos++;
        for (k = n; k > pos; k--)
            win_sorted[k] = win_sorted[k-1];
        win_sorted[pos] = v;
    endfunction

    function automatic void predict_sample(input logic [SAMPLE_BITS_DEF-1:0] s,
                                           output median_result_t r);
        int eff;
        int pos;
        int k;
        logic [SAMPLE_BITS_DEF:0]   thr;
        logic [SAMPLE_BITS_DEF-1:0] old;
        if (cur_size == 0)
            eff = 1;
        else if (cur_size > WINDOW_MAX_DEF)
            eff = WINDOW_MAX_DEF;
        else
            eff = int'(cur_size);
        r.full = 1'b0;
        r.alert = 1'b0;
        if (fill >= eff)
        begin
            r.full = 1'b1;
            if (eff % 2 == 1)
                thr = {win_sorted[eff/2], 1'b0};
            else
                thr = {1'b0, win_sorted[eff/2-1]} + {1'b0, win_sorted[eff/2]};
            if ({1'b0, s} >= thr)
            begin
                r.alert = 1'b1;
                if (alert_total != '1)
                    alert_total++;
            end
            if (oldest >= eff)
                oldest = 0;
            // drop the oldest sample from the sorted copy
            old = win_ring[oldest];
            pos = 0;
            while (pos < eff && win_sorted[pos] < old)
                pos++;
            if (pos < eff && win_sorted[pos] == old)
            begin
                for (k = pos; k + 1 < eff; k++)
                    win_sorted[k] = win_sorted[k+1];
            end
            sorted_insert(eff - 1, s);
            win_ring[oldest] = s;
            oldest++;
            if (oldest >= eff)
                oldest = 0;
        end
        else
        begin
            sorted_insert(fill, s);
            win_ring[fill] = s;
            fill++;
            oldest = 0;
        end
        r.count = alert_total;
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(input int base);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10)
            v = $urandom_range(0, 65535);
        else if (r < 14)
            v = 0;
        else if (r < 18)
            v = 65535;
        else if (r < 32)
            v = 2 * base + $urandom_range(0, 4) - 2;
        else if (r < 38)
            v = 3 * base;
        else
            v = base + $urandom_range(0, base / 4 + 1) - base / 8;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
        median_result_t r;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sample(s, r);
        flag_exp_q = {flag_exp_q, r};
        samples_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flag_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        window_size <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_size = v;
        fill = 0;
        oldest = 0;
        size_writes++;
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        median_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (flag_exp_q.size() == 0)
            begin
                $error("unexpected result: window_full %0d alert %0d alert_count %0d",
                       window_full, alert, alert_count);
                fail_count++;
            end
            else
            begin
                want = flag_exp_q.pop_front();
                results_checked++;
                if (window_full !== want.full)
                begin
                    $error("window_full mismatch: expected %0d, actual %0d",
                           want.full, window_full);
                    fail_count++;
                end
                if (alert !== want.alert)
                begin
                    $error("alert mismatch: expected %0d, actual %0d", want.alert, alert);
                    fail_count++;
                end
                if (alert_count !== want.count)
                begin
                    $error("alert_count mismatch: expected %0d, actual %0d",
                           want.count, alert_count);
                    fail_count++;
                end
            end
        end
    end

    // reset size of five, fill then odd median threshold around equality
    task automatic test_odd_median();
        push_sample(16'd10);
        push_sample(16'd50);
        push_sample(16'd30);
        push_sample(16'd20);
        push_sample(16'd40);
        push_sample(16'd59);
        push_sample(16'd80);
        push_sample(16'hFFFF);
        push_sample(16'd0);
        drain_results();
    endtask

    // even size: exact sum of the two middle values, no rounding of the mean
    task automatic test_even_median();
        write_size(7'd4);
        push_sample(16'd1);
        push_sample(16'd2);
        push_sample(16'd3);
        push_sample(16'd8);
        push_sample(16'd4);
        push_sample(16'd7);
        drain_results();
    endtask

    // size zero acts as one, then a real size of one
    task automatic test_tiny_windows();
        write_size(7'd0);
        push_sample(16'd0);
        push_sample(16'd0);
        push_sample(16'hFFFF);
        push_sample(16'd1);
        write_size(7'd1);
        push_sample(16'd5);
        push_sample(16'd9);
        push_sample(16'd18);
        drain_results();
    endtask

    task automatic test_random_sizes();
        int size_list [13] = '{64, 127, 65, 2, 3, 1, 7, 16, 33, 8, 0, 63, 6};
        int i;
        int j;
        int base;
        for (i = 0; i < 13; i++)
        begin
            write_size(CFG_W'(size_list[i]));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            base = $urandom_range(1, 20000);
            for (j = 0; j < 120; j++)
                push_sample(pick_sample(base));
        end
        drain_results();
    endtask

    // long receiver hold-off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        int j;
        int base;
        write_size(7'd3);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        base = $urandom_range(100, 5000);
        long_hold_req = 1'b1;
        for (j = 0; j < 30; j++)
            push_sample(pick_sample(base));
        drain_results();
    endtask

    task automatic test_no_idle();
        int j;
        int base;
        write_size(7'd9);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        base = $urandom_range(1, 20000);
        for (j = 0; j < 80; j++)
            push_sample(pick_sample(base));
        drain_results();
    endtask

    initial
    begin
        foreach (win_sorted[k])
        begin
            win_sorted[k] = '0;
            win_ring[k] = '0;
        end
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sample <= '0;
        cfg_valid <= 1'b0;
        window_size <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_odd_median();
        test_even_median();
        test_tiny_windows();
        test_random_sizes();
        test_backpressure();
        test_no_idle();

        // results trail their transfers through the input and output registers
        repeat (4) @(posedge clk);
        if (flag_exp_q.size() != 0)
        begin
            $error("%0d expected results never arrived", flag_exp_q.size());
            fail_count++;
        end
        $display("covered %0d samples and %0d checked results over %0d window_size writes",
                 samples_sent, results_checked, size_writes);
        $display("sizes from 0 to 127 incl. clamping, odd and even medians, long output hold-off");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/smof_pkg.sv
design/sliding_median_outlier_flag_core.sv
bench/tb_sliding_median_outlier_flag_core.sv
